// ===== hdl/sbqg_pkg.sv =====
`timescale 1ns / 1ps

package sbqg_pkg;

    // Stream widths, whole bytes
    localparam int S_TDATA_W = 264;
    localparam int M_TDATA_W = 152;
    localparam int SLOT_OUT_W = 5;

    localparam int SLOT_COUNT_DEF = 16;

    localparam logic [15:0] SPRITE_CAP_RST = 16'd1024;
    localparam logic [31:0] WHITE = 32'hFFFF_FFFF;

    // Register index, taken from paddr[2]
    localparam logic REG_SPRITE_CAP = 1'b0;

    // Command kinds on tuser
    localparam logic OP_RECT   = 1'b0;
    localparam logic OP_SPRITE = 1'b1;
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MISS,
        S_STORE,
        S_VERT
    } t_state;

    typedef struct packed {
        logic load;
        logic emit_flush;
        logic emit_vert;
        logic scan_start;
        logic scan;
        logic take_hit;
        logic store;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic count_full;
        logic textured;
        logic issue;
        logic rd_vld;
        logic hit;
        logic table_full;
        logic vert_last;
    } t_status;

endpackage

// ===== hdl/sprite_batch_quad_generator_top.sv =====
`timescale 1ns / 1ps

// Sprite batch quad generator. Each input item is a draw command (tuser 0 flat
// rectangle, 1 textured sprite) and yields four corner vertices, (x,y),
// (x,y+h), (x+w,y+h), (x+w,y), the fourth marked by tlast; x+w and y+h
// saturate. The vertices may be preceded by flush items (tuser 1) carrying the
// batch sprite count: one when the count has reached the sprite cap, and one
// when a sprite's new texture id finds the SLOT_COUNT-entry slot table full. A
// flush clears the count and the table. With the output ready, a rectangle or
// untextured sprite goes through accept, check and its four vertices; a flush
// goes out in the check or miss-decision state, not in a state of its own. A
// textured sprite adds a scan of the single-read-port slot table, which reads
// the used slots in order: a hit ends the scan, while a miss lets the read pipe
// drain and then takes the miss decision and the table write. The next command
// is accepted while the last vertex still waits in the output register. The
// sprite cap register (16 bits, reset 1024) lives at APB address 0; write it
// only while idle.

module sprite_batch_quad_generator_top #(
    parameter int SLOT_COUNT = sbqg_pkg::SLOT_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command input
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // dest_x[31:0] dest_y[63:32] dest_w[95:64] dest_h[127:96]
    // src_left[144:128] src_top[161:145] src_right[178:162] src_bottom[195:179]
    // texture_handle[227:196] rgba[259:228], zero fill to 263
    input  logic [sbqg_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [0:0]                     i_s_tuser,   // op
    // Result output
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // pos_x[31:0] pos_y[63:32] tex_u[80:64] tex_v[97:81] slot[102:98]
    // vertex_color[134:103] batch_sprites[150:135], zero fill bit 151
    output logic [sbqg_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [0:0]                     o_m_tuser,   // kind
    output logic                           o_m_tlast,   // last
    // Register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [15:0]       r_sprite_cap;
    sbqg_pkg::t_cmd    cmd;
    sbqg_pkg::t_status st;

    // Register index is the word address; odd words are unused
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_cap <= sbqg_pkg::SPRITE_CAP_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == sbqg_pkg::REG_SPRITE_CAP) begin
            r_sprite_cap <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sbqg_pkg::REG_SPRITE_CAP) ? {16'd0, r_sprite_cap} : 32'd0;

    sbqg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    sbqg_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_sprite_cap  (r_sprite_cap),
        .i_cmd         (cmd),
        .o_st          (st),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

endmodule

// ===== hdl/sbqg_ctrl.sv =====
`timescale 1ns / 1ps

module sbqg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  sbqg_pkg::t_status i_st,
    output sbqg_pkg::t_cmd    o_cmd
);

    sbqg_pkg::t_state r_state;
    sbqg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbqg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbqg_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = sbqg_pkg::S_CHECK;
            end
            sbqg_pkg::S_CHECK: begin
                if (!i_st.count_full || i_st.out_free) begin
                    n_state = i_st.textured ? sbqg_pkg::S_SCAN : sbqg_pkg::S_VERT;
                end
            end
            sbqg_pkg::S_SCAN: begin
                if (i_st.hit) begin
                    n_state = sbqg_pkg::S_VERT;
                end else if (!i_st.issue && !i_st.rd_vld) begin
                    n_state = sbqg_pkg::S_MISS;
                end
            end
            sbqg_pkg::S_MISS: begin
                if (!i_st.table_full || i_st.out_free) n_state = sbqg_pkg::S_STORE;
            end
            sbqg_pkg::S_STORE: begin
                n_state = sbqg_pkg::S_VERT;
            end
            sbqg_pkg::S_VERT: begin
                if (i_st.out_free && i_st.vert_last) n_state = sbqg_pkg::S_IDLE;
            end
            default: begin
                n_state = sbqg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_s_tready = 1'b0;
        case (r_state)
            sbqg_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            sbqg_pkg::S_CHECK: begin
                if (!i_st.count_full || i_st.out_free) begin
                    o_cmd.emit_flush = i_st.count_full;
                    o_cmd.scan_start = i_st.textured;
                end
            end
            sbqg_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                o_cmd.take_hit = i_st.hit;
            end
            sbqg_pkg::S_MISS: begin
                o_cmd.emit_flush = i_st.table_full && i_st.out_free;
            end
            sbqg_pkg::S_STORE: begin
                o_cmd.store = 1'b1;
            end
            sbqg_pkg::S_VERT: begin
                o_cmd.emit_vert = i_st.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/sbqg_dpath.sv =====
`timescale 1ns / 1ps

module sbqg_dpath #(
    parameter int SLOT_COUNT = sbqg_pkg::SLOT_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sbqg_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic [0:0]                       i_s_tuser,
    input  logic [15:0]                      i_sprite_cap,
    input  sbqg_pkg::t_cmd                   i_cmd,
    output sbqg_pkg::t_status                o_st,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [sbqg_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic [0:0]                       o_m_tuser,
    output logic                             o_m_tlast
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int USED_W = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_OUT_W_L = sbqg_pkg::SLOT_OUT_W;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

    // Captured command
    logic        r_sprite;
    logic [31:0] r_x0, r_y0, r_x1, r_y1;
    logic [16:0] r_sl, r_st, r_sr, r_sb;
    logic [31:0] r_tid;
    logic [31:0] r_col;

    // Batch state
    logic [15:0]       r_count;
    logic [USED_W-1:0] r_used;
    logic [USED_W-1:0] r_slot;
    logic [1:0]        r_vert;

    // Slot table and scan pipe
    logic [31:0]       r_slot_ids [SLOT_COUNT];
    logic [USED_W-1:0] r_scan_pos;
    logic [31:0]       r_rd_data;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_vld;

    // Output register
    logic              r_out_vld;
    logic              r_o_kind;
    logic [31:0]       r_o_px, r_o_py;
    logic [16:0]       r_o_u, r_o_v;
    logic [SLOT_OUT_W_L-1:0] r_o_slot;
    logic [31:0]       r_o_col;
    logic [15:0]       r_o_batch;
    logic              r_o_last;

    logic              issue;
    logic [SLOT_OUT_W_L+USED_W-1:0] slot_ext;
    logic [31:0]       v_px, v_py;
    logic [16:0]       v_u, v_v;

    assign issue    = r_scan_pos < r_used;
    assign slot_ext = {{SLOT_OUT_W_L{1'b0}}, r_slot};

    assign o_st.out_free   = !r_out_vld || i_m_tready;
    assign o_st.count_full = r_count >= i_sprite_cap;
    assign o_st.textured   = r_sprite && (r_tid != 32'd0);
    assign o_st.issue      = issue;
    assign o_st.rd_vld     = r_rd_vld;
    assign o_st.hit        = r_rd_vld && (r_rd_data == r_tid);
    assign o_st.table_full = r_used >= USED_W'(SLOT_COUNT);
    assign o_st.vert_last  = r_vert == 2'd3;

    // Corner order: (x,y) (x,y+h) (x+w,y+h) (x+w,y)
    always_comb begin
        case (r_vert)
            2'd0: begin v_px = r_x0; v_py = r_y0; v_u = r_sl; v_v = r_sb; end
            2'd1: begin v_px = r_x0; v_py = r_y1; v_u = r_sl; v_v = r_st; end
            2'd2: begin v_px = r_x1; v_py = r_y1; v_u = r_sr; v_v = r_st; end
            default: begin v_px = r_x1; v_py = r_y0; v_u = r_sr; v_v = r_sb; end
        endcase
    end

    // Command capture; rectangles carry zero texture edges
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sprite <= i_s_tuser[0] == sbqg_pkg::OP_SPRITE;
            r_x0 <= i_s_tdata[31:0];
            r_y0 <= i_s_tdata[63:32];
            r_x1 <= sat_add(i_s_tdata[31:0], i_s_tdata[95:64]);
            r_y1 <= sat_add(i_s_tdata[63:32], i_s_tdata[127:96]);
            r_sl <= (i_s_tuser[0] == sbqg_pkg::OP_SPRITE) ? i_s_tdata[144:128] : 17'd0;
            r_st <= (i_s_tuser[0] == sbqg_pkg::OP_SPRITE) ? i_s_tdata[161:145] : 17'd0;
            r_sr <= (i_s_tuser[0] == sbqg_pkg::OP_SPRITE) ? i_s_tdata[178:162] : 17'd0;
            r_sb <= (i_s_tuser[0] == sbqg_pkg::OP_SPRITE) ? i_s_tdata[195:179] : 17'd0;
            r_tid <= i_s_tdata[227:196];
            r_col <= (i_s_tuser[0] == sbqg_pkg::OP_SPRITE) ? sbqg_pkg::WHITE
                                                            : i_s_tdata[259:228];
        end
    end

    // Batch counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_used  <= '0;
            r_vert  <= '0;
        end else begin
            if (i_cmd.emit_flush) begin
                r_count <= '0;
                r_used  <= '0;
            end else begin
                if (i_cmd.store) r_used <= r_used + USED_W'(1);
                if (i_cmd.emit_vert && r_vert == 2'd3) r_count <= r_count + 16'd1;
            end
            if (i_cmd.load) begin
                r_vert <= '0;
            end else if (i_cmd.emit_vert) begin
                r_vert <= r_vert + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot <= '0;
        end else if (i_cmd.take_hit) begin
            r_slot <= USED_W'(r_rd_idx) + USED_W'(1);
        end else if (i_cmd.store) begin
            r_slot <= r_used + USED_W'(1);
        end
    end

    // Slot table: one write and one read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_slot_ids[r_used[IDX_W-1:0]] <= r_tid;
        if (i_cmd.scan && issue) begin
            r_rd_data <= r_slot_ids[r_scan_pos[IDX_W-1:0]];
            r_rd_idx  <= r_scan_pos[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pos <= '0;
            r_rd_vld   <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_scan_pos <= '0;
            r_rd_vld   <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= issue;
            if (issue) r_scan_pos <= r_scan_pos + USED_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_flush || i_cmd.emit_vert) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_flush) begin
            r_o_kind  <= sbqg_pkg::KIND_FLUSH;
            r_o_px    <= '0;
            r_o_py    <= '0;
            r_o_u     <= '0;
            r_o_v     <= '0;
            r_o_slot  <= '0;
            r_o_col   <= '0;
            r_o_batch <= r_count;
            r_o_last  <= 1'b0;
        end else if (i_cmd.emit_vert) begin
            r_o_kind  <= sbqg_pkg::KIND_VERTEX;
            r_o_px    <= v_px;
            r_o_py    <= v_py;
            r_o_u     <= v_u;
            r_o_v     <= v_v;
            r_o_slot  <= slot_ext[SLOT_OUT_W_L-1:0];
            r_o_col   <= r_col;
            r_o_batch <= '0;
            r_o_last  <= r_vert == 2'd3;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_o_batch, r_o_col, r_o_slot, r_o_v, r_o_u, r_o_py, r_o_px};
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;

endmodule
